[sv/clc_pkg.sv]
// ----------------------------------------------------------------------------
// clc_pkg
// Types, character codes and token classification for the command lexer.
// ----------------------------------------------------------------------------
package clc_pkg;

    // Line limit: positions stop at LINE_MAX-1, lengths at LINE_MAX
    localparam int unsigned LINE_MAX   = 4096;
    localparam logic [11:0] POS_LAST   = 12'(LINE_MAX - 1);
    localparam logic [12:0] LEN_LAST   = 13'(LINE_MAX);

    // Token queue between front and back
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_PIPE   = 8'h7C;  // |
    localparam logic [7:0] CH_AMP    = 8'h26;  // &
    localparam logic [7:0] CH_LT     = 8'h3C;  // <
    localparam logic [7:0] CH_GT     = 8'h3E;  // >
    localparam logic [7:0] CH_LPAR   = 8'h28;  // (
    localparam logic [7:0] CH_RPAR   = 8'h29;  // )
    localparam logic [7:0] CH_SEMI   = 8'h3B;  // ;
    localparam logic [7:0] CH_DOLLAR = 8'h24;  // $
    localparam logic [7:0] CH_DASH   = 8'h2D;  // -
    localparam logic [7:0] CH_SQUOTE = 8'h27;  // '
    localparam logic [7:0] CH_DQUOTE = 8'h22;  // "
    localparam logic [7:0] CH_CARET  = 8'h5E;  // ^
    localparam logic [7:0] CH_UNDER  = 8'h5F;  // _
    localparam logic [7:0] CH_STAR   = 8'h2A;  // *
    localparam logic [7:0] CH_DOT    = 8'h2E;  // .
    localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Token kinds
    localparam logic [3:0] KIND_WORD      = 4'd0;
    localparam logic [3:0] KIND_PIPE      = 4'd1;
    localparam logic [3:0] KIND_SEMI      = 4'd2;
    localparam logic [3:0] KIND_DOLLAR    = 4'd3;
    localparam logic [3:0] KIND_FLAG      = 4'd4;
    localparam logic [3:0] KIND_SQUOTE    = 4'd5;
    localparam logic [3:0] KIND_DQUOTE    = 4'd6;
    localparam logic [3:0] KIND_AND       = 4'd7;
    localparam logic [3:0] KIND_OR        = 4'd8;
    localparam logic [3:0] KIND_LPAREN    = 4'd9;
    localparam logic [3:0] KIND_RPAREN    = 4'd10;
    localparam logic [3:0] KIND_HEREDOC   = 4'd11;
    localparam logic [3:0] KIND_APPEND    = 4'd12;
    localparam logic [3:0] KIND_REDIR_OUT = 4'd13;
    localparam logic [3:0] KIND_REDIR_IN  = 4'd14;
    localparam logic [3:0] KIND_ERROR     = 4'd15;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WORD  = 2'd1,
        MODE_OPER  = 2'd2,
        MODE_QUOTE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CLS_SPACE = 3'd0,
        CLS_WORD  = 3'd1,
        CLS_OPER  = 3'd2,
        CLS_QUOTE = 3'd3,
        CLS_OTHER = 3'd4
    } t_cls;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_line;
    } t_in;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [11:0] token_start;
        logic [12:0] token_length;
        logic        last_of_item;
    } t_out;

    // Closed run, not yet typed
    typedef struct packed {
        logic [7:0]  first;
        logic [7:0]  second;
        logic [11:0] start;
        logic [12:0] len;
    } t_raw;

    // All tokens caused by one input byte (one or two)
    typedef struct packed {
        logic two;
        t_raw tok0;
        t_raw tok1;
    } t_pair;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic t_cls classify(input logic [7:0] c);
        t_cls cls;
        if (c == CH_SPACE || (c inside {[8'h09:8'h0D]}))
            cls = CLS_SPACE;
        else if (is_letter(c) || (c inside {[8'h30:8'h39]}) ||
                 (c inside {CH_CARET, CH_DASH, CH_UNDER, CH_STAR, CH_DOT,
                            CH_DOLLAR, CH_BSLASH}))
            cls = CLS_WORD;
        else if (c inside {CH_PIPE, CH_AMP, CH_LT, CH_GT, CH_LPAR, CH_RPAR, CH_SEMI})
            cls = CLS_OPER;
        else if (c inside {CH_SQUOTE, CH_DQUOTE})
            cls = CLS_QUOTE;
        else
            cls = CLS_OTHER;
        return cls;
    endfunction

    // Kind from the first two bytes and length, first match wins
    function automatic logic [3:0] kind_of(input logic [7:0] a, input logic [7:0] b,
                                           input logic [12:0] len);
        logic       one;
        logic       two;
        logic [3:0] k;
        one = (len == 13'd1);
        two = (len == 13'd2);
        if (is_letter(a))                                 k = KIND_WORD;
        else if (one && a == CH_PIPE)                     k = KIND_PIPE;
        else if (one && a == CH_SEMI)                     k = KIND_SEMI;
        else if (one && a == CH_DOLLAR)                   k = KIND_DOLLAR;
        else if (len >= 13'd2 && a == CH_DASH)            k = KIND_FLAG;
        else if (a == CH_SQUOTE)                          k = KIND_SQUOTE;
        else if (a == CH_DQUOTE)                          k = KIND_DQUOTE;
        else if (two && a == CH_AMP && b == CH_AMP)       k = KIND_AND;
        else if (two && a == CH_PIPE && b == CH_PIPE)     k = KIND_OR;
        else if (one && a == CH_LPAR)                     k = KIND_LPAREN;
        else if (one && a == CH_RPAR)                     k = KIND_RPAREN;
        else if (two && a == CH_LT && b == CH_LT)         k = KIND_HEREDOC;
        else if (two && a == CH_GT && b == CH_GT)         k = KIND_APPEND;
        else if (one && a == CH_GT)                       k = KIND_REDIR_OUT;
        else if (one && a == CH_LT)                       k = KIND_REDIR_IN;
        else                                              k = KIND_ERROR;
        return k;
    endfunction

endpackage

[sv/shell_command_lexer.sv]
// ----------------------------------------------------------------------------
// shell_command_lexer
// Splits a command line, one byte per word, into typed tokens with start
// offset and length.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+---------------------------
//   in      | i_valid | o_stall | i_data  (char, end of line)
//   out     | o_valid | i_stall | o_data  (kind, start, length, last)
//
// One byte is taken per cycle while the token queue has room.
// A byte yields zero, one or two tokens; the output register sends one token
// per cycle while the output is not stalled, so a byte that makes two tokens
// is sent as two output words. A byte's tokens pass the queue and then the
// output register before they are offered.
// Reset is synchronous; it clears run tracking, the line position and the queue.
// The queue holds four entries and input stalls while it is full.
// ----------------------------------------------------------------------------
module shell_command_lexer
    import clc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_stall,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    logic  push;
    logic  pop;
    logic  full;
    logic  q_valid;
    t_pair push_pair;
    t_pair head_pair;

    clc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .i_full  (full),
        .o_push  (push),
        .o_pair  (push_pair)
    );

    clc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (push_pair),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_pair  (head_pair)
    );

    clc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_pair  (head_pair),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule

[sv/clc_front.sv]
// ----------------------------------------------------------------------------
// clc_front
// Takes one byte per cycle while the queue is not full, tracks the open run
// and pushes the runs that the byte closes (one or two) as a single queue entry.
// ----------------------------------------------------------------------------
module clc_front
    import clc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_in   i_data,
    output logic  o_stall,
    input  logic  i_full,
    output logic  o_push,
    output t_pair o_pair
);

    t_mode       r_mode,   n_mode;
    logic        r_dq,     n_dq;
    logic [11:0] r_start,  n_start;
    logic [12:0] r_len,    n_len;
    logic [7:0]  r_first,  n_first;
    logic [7:0]  r_second, n_second;
    logic [11:0] r_pos,    n_pos;

    logic        accept;
    logic [7:0]  c;
    t_cls        cls;
    logic [7:0]  quote_ch;
    logic [1:0]  cnt;
    t_raw        tok0;
    t_raw        tok1;
    t_raw        cur;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign c       = i_data.char_byte;
    assign cls     = classify(c);
    assign quote_ch = r_dq ? CH_DQUOTE : CH_SQUOTE;

    // Run tracking and token emission
    always_comb begin
        n_mode   = r_mode;
        n_dq     = r_dq;
        n_start  = r_start;
        n_len    = r_len;
        n_first  = r_first;
        n_second = r_second;
        n_pos    = r_pos;
        cnt      = 2'd0;
        tok0     = '0;
        tok1     = '0;
        cur      = '{first: r_first, second: r_second, start: r_start, len: r_len};

        if (r_mode == MODE_QUOTE) begin
            if (r_len == 13'd1) n_second = c;
            if (r_len < LEN_LAST) n_len = r_len + 13'd1;
            if (c == quote_ch) begin
                tok0   = '{first: r_first, second: n_second, start: r_start, len: n_len};
                cnt    = 2'd1;
                n_mode = MODE_IDLE;
            end
        end else if ((r_mode == MODE_WORD && cls == CLS_WORD) ||
                     (r_mode == MODE_OPER && cls == CLS_OPER)) begin
            if (r_len == 13'd1) n_second = c;
            if (r_len < LEN_LAST) n_len = r_len + 13'd1;
        end else begin
            // close the open run, then open a new one if this byte starts a run
            if (r_mode != MODE_IDLE) begin
                tok0   = cur;
                cnt    = 2'd1;
                n_mode = MODE_IDLE;
            end
            case (cls)
                CLS_WORD, CLS_OPER, CLS_QUOTE: begin
                    n_mode   = (cls == CLS_WORD) ? MODE_WORD :
                               (cls == CLS_OPER) ? MODE_OPER : MODE_QUOTE;
                    n_start  = r_pos;
                    n_len    = 13'd1;
                    n_first  = c;
                    n_second = 8'd0;
                    if (cls == CLS_QUOTE) n_dq = (c == CH_DQUOTE);
                end
                CLS_OTHER: begin
                    // stray byte: one-byte error token
                    if (cnt == 2'd0) begin
                        tok0 = '{first: c, second: 8'd0, start: r_pos, len: 13'd1};
                    end else begin
                        tok1 = '{first: c, second: 8'd0, start: r_pos, len: 13'd1};
                    end
                    cnt = cnt + 2'd1;
                end
                default: ;
            endcase
        end

        // end of line flushes whatever is open
        if (i_data.end_of_line) begin
            if (n_mode != MODE_IDLE) begin
                if (cnt == 2'd0) begin
                    tok0 = '{first: n_first, second: n_second, start: n_start, len: n_len};
                end else begin
                    tok1 = '{first: n_first, second: n_second, start: n_start, len: n_len};
                end
                cnt    = cnt + 2'd1;
                n_mode = MODE_IDLE;
            end
            n_pos = 12'd0;
        end else if (r_pos < POS_LAST) begin
            n_pos = r_pos + 12'd1;
        end
    end

    assign o_push = accept && (cnt != 2'd0);
    assign o_pair = '{two: cnt[1], tok0: tok0, tok1: tok1};

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_dq     <= 1'b0;
            r_start  <= '0;
            r_len    <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_pos    <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_dq     <= n_dq;
            r_start  <= n_start;
            r_len    <= n_len;
            r_first  <= n_first;
            r_second <= n_second;
            r_pos    <= n_pos;
        end
    end

endmodule

[sv/clc_fifo.sv]
// ----------------------------------------------------------------------------
// clc_fifo
// Short queue of token pairs between the front and the back.
// ----------------------------------------------------------------------------
module clc_fifo
    import clc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_pair,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_pair o_pair
);

    t_pair              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, n_wr;
    logic [FIFO_AW-1:0] r_rd, n_rd;
    logic [FIFO_CW-1:0] r_count, n_count;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_pair  = r_mem[r_rd];

    // Pointer and occupancy update
    always_comb begin
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = i_pop  ? r_rd + 1'b1 : r_rd;
        n_count = r_count + FIFO_CW'(i_push) - FIFO_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_pair;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop) else $error("token queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("token queue underflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH)) else $error("token queue count out of range");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == FIFO_CW'(FIFO_DEPTH)) |-> r_wr == r_rd)
        else $error("token queue pointers disagree with count");
`endif

endmodule

[sv/clc_back.sv]
// ----------------------------------------------------------------------------
// clc_back
// Types queued runs and sends them out one word per cycle while not stalled,
// through an output register; a pair is sent as two words.
// ----------------------------------------------------------------------------
module clc_back
    import clc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_pair i_q_pair,
    output logic  o_pop,
    output logic  o_valid,
    output t_out  o_data,
    input  logic  i_stall
);

    logic r_valid, n_valid;
    logic r_sub,   n_sub;
    t_out r_data,  n_data;
    logic load;
    t_raw tok;

    assign load  = i_q_valid && (!r_valid || !i_stall);
    assign tok   = r_sub ? i_q_pair.tok1 : i_q_pair.tok0;
    assign o_pop = load && (r_sub || !i_q_pair.two);

    // Next output word
    always_comb begin
        n_data = '{token_kind:   kind_of(tok.first, tok.second, tok.len),
                   token_start:  tok.start,
                   token_length: tok.len,
                   last_of_item: o_pop};
        n_valid = load ? 1'b1 : (r_valid && i_stall);
        n_sub   = load ? !o_pop : r_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

`ifndef SYNTHESIS
    a_sub_only_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub && i_q_valid) |-> i_q_pair.two) else $error("second slot of a single");
    a_last_ends_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && o_pop) |=> (o_data.last_of_item && !r_sub))
        else $error("pair end not marked last");
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !o_pop) |=> (!o_data.last_of_item && r_sub))
        else $error("first of pair marked last");
`endif

endmodule

[dv/shell_command_lexer_test.sv]
// ----------------------------------------------------------------------------
// shell_command_lexer_test
// Self-checking bench for the command line lexer. Bytes go in one word per
// handshake; every input word is run through a local token predictor and
// each token that comes out is matched, in order, against the predicted
// tokens. A short table of hand-picked bytes comes first, then random lines:
// mostly well-formed commands, some noise and some broken lines.
// ----------------------------------------------------------------------------
module shell_command_lexer_test;
    import clc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;  // cycles with no handshake at all
    localparam int DRAIN_WAIT  = 16;
    localparam int ITEM_COUNT  = 400;   // minimum input words for the whole run

    typedef enum logic [3:0] {
        P_WORD, P_FLAG, P_PIPE, P_OR, P_AND, P_SEMI, P_DOLLAR,
        P_LPAREN, P_RPAREN, P_REDIR, P_QUOTE, P_ODD
    } t_piece;

    // One directed byte; want is used only where typed is set
    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
        logic       typed;
        t_out       want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    t_in  i_data;
    logic o_stall;
    logic o_valid;
    t_out o_data;
    logic i_stall;

    shell_command_lexer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    // Predictor state
    t_mode       scan_mode;
    logic        quote_dq;
    logic [11:0] tok_start;
    logic [12:0] tok_len;
    logic [7:0]  tok_c0;
    logic [7:0]  tok_c1;
    logic [11:0] col;
    t_out        step_toks[$];
    t_out        tokens_due[$];

    // Stimulus side
    logic [7:0]  line_buf[$];
    logic        typed_on;
    t_out        typed_want;
    bit          steady;
    int          fail_count;
    int          chars_sent;
    int          lines_sent;
    int          tokens_checked;
    int          quiet_cycles;

    string OP_SET   = "|&<>();";
    string WORD_SET = "0123456789^-_*.$\\abcxyzABCXYZ";
    string ODD_SET  = "!#%+,/:=?@[]`{}~";

    // Directed bytes: two lines, then a lone byte on a fresh line
    t_dir_row dir_rows [26] = '{
        '{8'h00,     1'b0, 1'b1, '{KIND_ERROR, 12'd0, 13'd1, 1'b1}},
        '{"l",       1'b0, 1'b0, '0},
        '{"s",       1'b0, 1'b0, '0},
        '{CH_SPACE,  1'b0, 1'b0, '0},  // word
        '{CH_DASH,   1'b0, 1'b0, '0},
        '{"x",       1'b0, 1'b0, '0},
        '{CH_PIPE,   1'b0, 1'b0, '0},  // flag
        '{CH_PIPE,   1'b0, 1'b0, '0},
        '{CH_DOLLAR, 1'b0, 1'b0, '0},  // or
        '{CH_GT,     1'b0, 1'b0, '0},  // dollar
        '{CH_GT,     1'b0, 1'b0, '0},
        '{"a",       1'b0, 1'b0, '0},  // append
        '{CH_LT,     1'b0, 1'b0, '0},  // word
        '{CH_LT,     1'b0, 1'b0, '0},
        '{8'hFF,     1'b0, 1'b0, '0},  // heredoc, then error for the byte itself
        '{CH_SQUOTE, 1'b0, 1'b0, '0},
        '{CH_DQUOTE, 1'b0, 1'b0, '0},
        '{CH_SQUOTE, 1'b0, 1'b0, '0},  // single quoted span
        '{CH_DQUOTE, 1'b0, 1'b0, '0},
        '{"q",       1'b1, 1'b0, '0},  // double quote left open at end of line
        '{CH_AMP,    1'b0, 1'b0, '0},
        '{CH_AMP,    1'b0, 1'b0, '0},
        '{8'h09,     1'b0, 1'b0, '0},  // and
        '{"7",       1'b0, 1'b0, '0},
        '{CH_LT,     1'b1, 1'b0, '0},  // digit run is an error, then redir in
        '{8'hFF,     1'b1, 1'b1, '{KIND_ERROR, 12'd0, 13'd1, 1'b1}}
    };

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic t_cls char_class(input logic [7:0] c);
        if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D))
            return CLS_SPACE;
        if (is_alpha(c) || (c >= "0" && c <= "9") || c == CH_CARET || c == CH_DASH ||
            c == CH_UNDER || c == CH_STAR || c == CH_DOT || c == CH_DOLLAR ||
            c == CH_BSLASH)
            return CLS_WORD;
        if (c == CH_PIPE || c == CH_AMP || c == CH_LT || c == CH_GT ||
            c == CH_LPAR || c == CH_RPAR || c == CH_SEMI)
            return CLS_OPER;
        if (c == CH_SQUOTE || c == CH_DQUOTE)
            return CLS_QUOTE;
        return CLS_OTHER;
    endfunction

    // Kind by leading byte; the second byte matters only for two-byte operators
    function automatic logic [3:0] token_kind_for(input logic [7:0] c0, input logic [7:0] c1,
                                                  input logic [12:0] len);
        logic one;
        logic pair;
        one  = (len == 13'd1);
        pair = (len == 13'd2) && (c1 == c0);
        case (c0)
            CH_SQUOTE: return KIND_SQUOTE;
            CH_DQUOTE: return KIND_DQUOTE;
            CH_DASH:   return one ? KIND_ERROR : KIND_FLAG;
            CH_PIPE:   return one ? KIND_PIPE : (pair ? KIND_OR : KIND_ERROR);
            CH_SEMI:   return one ? KIND_SEMI : KIND_ERROR;
            CH_DOLLAR: return one ? KIND_DOLLAR : KIND_ERROR;
            CH_AMP:    return pair ? KIND_AND : KIND_ERROR;
            CH_LPAR:   return one ? KIND_LPAREN : KIND_ERROR;
            CH_RPAR:   return one ? KIND_RPAREN : KIND_ERROR;
            CH_LT:     return one ? KIND_REDIR_IN : (pair ? KIND_HEREDOC : KIND_ERROR);
            CH_GT:     return one ? KIND_REDIR_OUT : (pair ? KIND_APPEND : KIND_ERROR);
            default:   return is_alpha(c0) ? KIND_WORD : KIND_ERROR;
        endcase
    endfunction

    task automatic emit(input logic [3:0] kind, input logic [11:0] start,
                        input logic [12:0] len);
        t_out t;
        t.token_kind   = kind;
        t.token_start  = start;
        t.token_length = len;
        t.last_of_item = 1'b0;
        step_toks.push_back(t);
    endtask

    task automatic close_token();
        emit(token_kind_for(tok_c0, tok_c1, tok_len), tok_start, tok_len);
        scan_mode = MODE_IDLE;
    endtask

    task automatic extend_token(input logic [7:0] c);
        if (tok_len == 13'd1)
            tok_c1 = c;
        if (tok_len != LEN_LAST)
            tok_len++;
    endtask

    task automatic begin_token(input t_mode m, input logic [7:0] c);
        scan_mode = m;
        tok_start = col;
        tok_len   = 13'd1;
        tok_c0    = c;
        tok_c1    = 8'h00;
    endtask

    // Tokens caused by one input word land in step_toks
    task automatic lex_predict(input t_in w);
        logic [7:0] c;
        t_cls       cls;
        c   = w.char_byte;
        cls = char_class(c);
        step_toks.delete();
        if (scan_mode == MODE_QUOTE) begin
            extend_token(c);
            if (c == (quote_dq ? CH_DQUOTE : CH_SQUOTE))
                close_token();
        end else if ((scan_mode == MODE_WORD && cls == CLS_WORD) ||
                     (scan_mode == MODE_OPER && cls == CLS_OPER)) begin
            extend_token(c);
        end else begin
            if (scan_mode != MODE_IDLE)
                close_token();
            case (cls)
                CLS_WORD:  begin_token(MODE_WORD, c);
                CLS_OPER:  begin_token(MODE_OPER, c);
                CLS_QUOTE: begin
                    begin_token(MODE_QUOTE, c);
                    quote_dq = (c == CH_DQUOTE);
                end
                CLS_OTHER: emit(KIND_ERROR, col, 13'd1);
                default: ;
            endcase
        end
        if (w.end_of_line) begin
            if (scan_mode != MODE_IDLE)
                close_token();
            col = '0;
        end else if (col != POS_LAST) begin
            col++;
        end
        if (step_toks.size() != 0)
            step_toks[step_toks.size() - 1].last_of_item = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted input, check accepted output, watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_out want;
        bit   moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            scan_mode = MODE_IDLE;
            quote_dq  = 1'b0;
            tok_start = '0;
            tok_len   = '0;
            tok_c0    = '0;
            tok_c1    = '0;
            col       = '0;
        end else begin
            if (i_valid && !o_stall) begin
                lex_predict(i_data);
                if (typed_on)
                    tokens_due.push_back(typed_want);
                else
                    foreach (step_toks[k]) tokens_due.push_back(step_toks[k]);
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                tokens_checked++;
                if (tokens_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: expected no token, got kind %0d start %0d len %0d last %0d",
                             $time, o_data.token_kind, o_data.token_start,
                             o_data.token_length, o_data.last_of_item);
                end else begin
                    want = tokens_due.pop_front();
                    if (o_data.token_kind !== want.token_kind ||
                        o_data.token_start !== want.token_start ||
                        o_data.token_length !== want.token_length ||
                        o_data.last_of_item !== want.last_of_item) begin
                        fail_count++;
                        $display("%0t: token mismatch: expected kind %0d start %0d len %0d last %0d",
                                 $time, want.token_kind, want.token_start,
                                 want.token_length, want.last_of_item);
                        $display("%0t:                 got kind %0d start %0d len %0d last %0d",
                                 $time, o_data.token_kind, o_data.token_start,
                                 o_data.token_length, o_data.last_of_item);
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d tokens outstanding",
                         $time, QUIET_LIMIT, tokens_due.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stall ahead of every token
    // ------------------------------------------------------------------
    initial begin : sink
        int hold;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            hold = steady ? 0 : $urandom_range(0, 9);
            if (hold != 0) begin
                i_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
                i_stall = 1'b0;
            end
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic eol, input logic typed,
                             input t_out want);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data.char_byte   = c;
        i_data.end_of_line = eol;
        typed_on           = typed;
        typed_want         = want;
        i_valid            = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        chars_sent++;
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
        lines_sent++;
    endtask

    // Hold input until every predicted token has come out
    task automatic drain();
        i_valid = 1'b0;
        while (tokens_due.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                    : 8'($urandom_range("A", "Z"));
    endfunction

    function automatic logic [7:0] rand_word_char();
        return $urandom_range(0, 1) ? rand_letter()
                                    : WORD_SET[$urandom_range(0, WORD_SET.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_blank();
        return $urandom_range(0, 2) != 0 ? CH_SPACE : 8'($urandom_range(9, 13));
    endfunction

    function automatic logic [7:0] rand_quote_body(input logic [7:0] q);
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == q);
        return c;
    endfunction

    task automatic add_piece(input t_piece p);
        logic [7:0] q;
        case (p)
            P_WORD: begin
                line_buf.push_back(rand_letter());
                repeat ($urandom_range(0, 6)) line_buf.push_back(rand_word_char());
            end
            P_FLAG: begin
                line_buf.push_back(CH_DASH);
                repeat ($urandom_range(1, 5)) line_buf.push_back(rand_word_char());
            end
            P_PIPE:   line_buf.push_back(CH_PIPE);
            P_OR:     repeat (2) line_buf.push_back(CH_PIPE);
            P_AND:    repeat (2) line_buf.push_back(CH_AMP);
            P_SEMI:   line_buf.push_back(CH_SEMI);
            P_DOLLAR: line_buf.push_back(CH_DOLLAR);
            P_LPAREN: line_buf.push_back(CH_LPAR);
            P_RPAREN: line_buf.push_back(CH_RPAR);
            P_REDIR: begin
                q = $urandom_range(0, 1) ? CH_LT : CH_GT;
                repeat ($urandom_range(1, 2)) line_buf.push_back(q);
            end
            P_QUOTE: begin
                q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                line_buf.push_back(q);
                repeat ($urandom_range(0, 6)) line_buf.push_back(rand_quote_body(q));
                line_buf.push_back(q);
            end
            default: begin
                // malformed: operator soup, digit-led run or a stray byte
                case ($urandom_range(0, 2))
                    0: repeat ($urandom_range(1, 4))
                           line_buf.push_back(OP_SET[$urandom_range(0, OP_SET.len() - 1)]);
                    1: begin
                        line_buf.push_back(8'($urandom_range("0", "9")));
                        repeat ($urandom_range(0, 3)) line_buf.push_back(rand_word_char());
                    end
                    default: line_buf.push_back($urandom_range(0, 1)
                                 ? 8'($urandom_range(128, 255))
                                 : ODD_SET[$urandom_range(0, ODD_SET.len() - 1)]);
                endcase
            end
        endcase
    endtask

    // style 0: noise, 1: ends in an open quote, otherwise a clean command
    task automatic build_line(input int style);
        logic [7:0] q;
        int         n;
        line_buf.delete();
        if (style == 0) begin
            repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(1, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0)
            line_buf.push_back(rand_blank());
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            add_piece(t_piece'($urandom_range(0, P_ODD)));
            // most pieces are separated; glued ones merge or split runs
            if (i < n - 1 && $urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 2)) line_buf.push_back(rand_blank());
        end
        if (style == 1) begin
            q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            line_buf.push_back(q);
            repeat ($urandom_range(0, 5)) line_buf.push_back(rand_quote_body(q));
        end else if ($urandom_range(0, 3) == 0) begin
            line_buf.push_back(rand_blank());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data         = '0;
        typed_on       = 1'b0;
        typed_want     = '0;
        steady         = 1'b0;
        fail_count     = 0;
        chars_sent     = 0;
        lines_sent     = 0;
        tokens_checked = 0;
        quiet_cycles   = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (dir_rows[i])
            send_char(dir_rows[i].ch, dir_rows[i].eol, dir_rows[i].typed, dir_rows[i].want);
        typed_on = 1'b0;
        drain();

        // random lines
        while (chars_sent < ITEM_COUNT) begin
            steady = ($urandom_range(0, 4) == 0);
            build_line($urandom_range(0, 9) < 2 ? $urandom_range(0, 1) : 2);
            send_line();
            if (lines_sent % 8 == 0)
                drain();
        end

        i_valid = 1'b0;
        while (tokens_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d bytes in %0d lines: hand-picked bytes, commands, noise, open quotes;",
                 chars_sent, lines_sent);
        $display("checked %0d tokens, %0d of them wrong or unexpected.",
                 tokens_checked, fail_count);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
